FILE: hdl/fixed_block_pool_allocator_core_assert.svh
// Assertion macros shared by the block pool allocator RTL.
// Depends on nothing; included by the top level after its logic.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

FILE: hdl/fbpa_pkg.sv
// Types and fixed constants of the block pool allocator.
// Used by fbpa_link_ram and fixed_block_pool_allocator_core.
package fbpa_pkg;

    localparam int NUM_BLOCKS  = 256;
    localparam int INDEX_W     = 8;
    localparam int COUNT_W     = 9;
    localparam int REQ_CFG_W   = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int OFFSET_W    = 20;
    localparam int ALIGN_BYTES = 16;
    localparam int MIN_BYTES   = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE  = 1'b1;

    typedef enum logic [1:0] {
        CMD_INIT    = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_ALLOC   = 2'd2,
        CMD_FREE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_INIT  = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_EXHAUSTED = 3'd3,
        ST_BAD_INDEX = 3'd4,
        ST_IGNORED   = 3'd5
    } status_t;

    // One free-list node: the next block and whether this node ends the list.
    typedef struct packed {
        logic [INDEX_W-1:0] link;
        logic               last;
    } link_entry_t;

    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] addr;
        link_entry_t        data;
    } link_wr_t;

endpackage

FILE: hdl/fbpa_link_ram.sv
// Free-list link memory: one write port, one registered read port.
// Depends on fbpa_pkg for the entry and write-port types.
module fbpa_link_ram
    import fbpa_pkg::*;
(
    input  logic               clk,
    input  link_wr_t           wr,
    input  logic               rd_en,
    input  logic [INDEX_W-1:0] rd_addr,
    output link_entry_t        rd_data
);

    link_entry_t mem [NUM_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/fixed_block_pool_allocator_core.sv
// Fixed-size block pool allocator with a LIFO free list in a link memory.
// Depends on fbpa_pkg, fbpa_link_ram and the assertion macro header.
//
// Usage: commands arrive as words on the in_valid/in_ready channel (cmd,
// request_size, block_index, null_pointer) and each produces exactly one
// result word on out_valid/out_ready (status, granted_index, byte_offset).
// A command is accepted and then executed: the acceptance cycle reads the
// link of the current head from the synchronous link memory, and the execute
// state then decides the result, updates the head and writes the link memory
// for a free. The result is registered, and a new command is taken only once
// the previous one has executed, since the link memory read is registered.
// An init that builds the pool gives its result at once, then chains the
// blocks in the link memory one entry per cycle, and the next command is
// taken only after that chaining is done.
// Reset empties the pool (not initialized), sets block_count to 256 and
// requested_block_size to 64; the link memory is read on every accepted
// command, but its data is used only after an init has written it. If the
// receiver stalls, the pending result is held; a new command word can still
// be accepted while it waits, but its execute step then waits until the
// result is taken. Configuration writes take effect at the next init.
module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCK_BYTES = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             cmd,
    input  logic [15:0]            request_size,
    input  logic [7:0]             block_index,
    input  logic                   null_pointer,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             status,
    output logic [7:0]             granted_index,
    output logic [19:0]            byte_offset
);

    localparam int EFF_MAX = ((MAX_BLOCK_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int SIZE_W  = $clog2(EFF_MAX + 1);
    localparam int CALC_W  = 18;
    localparam int PROD_W  = INDEX_W + SIZE_W;
    localparam int REQ_W   = 17;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_SWEEP = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  block_count_reg;
    logic [REQ_CFG_W-1:0] req_size_reg;

    cmd_t                cmd_reg;
    logic [15:0]         request_size_reg;
    logic [INDEX_W-1:0]  block_index_reg;
    logic                null_pointer_reg;

    logic [INDEX_W-1:0]  head_reg, head_next;
    logic                list_empty_reg, list_empty_next;
    logic                pool_ready_reg, pool_ready_next;
    logic [COUNT_W-1:0]  held_count_reg, held_count_next;
    logic [SIZE_W-1:0]   held_size_reg, held_size_next;
    logic [INDEX_W-1:0]  sweep_reg, sweep_next;

    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [INDEX_W-1:0]  granted_reg, granted_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;

    logic                accept;
    logic                exec_go;
    logic                sweep_last;
    logic                head_below_count;
    link_wr_t            link_wr;
    link_entry_t         link_rd;

    logic [CALC_W-1:0]   size_clip;
    logic [CALC_W-1:0]   size_round;
    logic [SIZE_W-1:0]   eff_size;
    logic [COUNT_W-1:0]  norm_count;
    logic [PROD_W-1:0]   product;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign exec_go   = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    assign sweep_last       = ({1'b0, sweep_reg} == held_count_reg - COUNT_W'(1));
    assign head_below_count = ({1'b0, head_reg} < held_count_reg);

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;
    assign byte_offset   = offset_reg;

    fbpa_link_ram u_link_ram (
        .clk     (clk),
        .wr      (link_wr),
        .rd_en   (accept),
        .rd_addr (head_reg),
        .rd_data (link_rd)
    );

    // Effective block size: clip to the maximum, raise to the minimum, then
    // round up to the alignment.
    always_comb
    begin
        size_clip = CALC_W'(req_size_reg);
        if (size_clip > CALC_W'(MAX_BLOCK_BYTES))
        begin
            size_clip = CALC_W'(MAX_BLOCK_BYTES);
        end
        if (size_clip < CALC_W'(MIN_BYTES))
        begin
            size_clip = CALC_W'(MIN_BYTES);
        end
        size_round = (size_clip + CALC_W'(ALIGN_BYTES - 1)) & ~CALC_W'(ALIGN_BYTES - 1);
        eff_size   = size_round[SIZE_W-1:0];
    end

    always_comb
    begin
        if (block_count_reg == '0)
        begin
            norm_count = COUNT_W'(1);
        end
        else if (block_count_reg > COUNT_W'(NUM_BLOCKS))
        begin
            norm_count = COUNT_W'(NUM_BLOCKS);
        end
        else
        begin
            norm_count = block_count_reg;
        end
    end

    assign product = PROD_W'(head_reg) * PROD_W'(held_size_reg);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        list_empty_next = list_empty_reg;
        pool_ready_next = pool_ready_reg;
        held_count_next = held_count_reg;
        held_size_next  = held_size_reg;
        sweep_next      = sweep_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        offset_next     = offset_reg;
        link_wr.en        = 1'b0;
        link_wr.addr      = block_index_reg;
        link_wr.data.link = head_reg;
        link_wr.data.last = list_empty_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            state_next = S_EXEC;
        end

        // After an init, block i is chained to block i + 1, one entry per cycle.
        if (state_reg == S_SWEEP)
        begin
            link_wr.en        = 1'b1;
            link_wr.addr      = sweep_reg;
            link_wr.data.link = sweep_reg + INDEX_W'(1);
            link_wr.data.last = sweep_last;
            if (sweep_last)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                sweep_next = sweep_reg + INDEX_W'(1);
            end
        end

        if (exec_go)
        begin
            state_next     = S_IDLE;
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            granted_next   = '0;
            offset_next    = '0;

            unique case (cmd_reg)
                CMD_INIT:
                begin
                    if (pool_ready_reg)
                    begin
                        status_next = ST_IGNORED;
                    end
                    else
                    begin
                        held_count_next = norm_count;
                        held_size_next  = eff_size;
                        head_next       = '0;
                        list_empty_next = 1'b0;
                        pool_ready_next = 1'b1;
                        sweep_next      = '0;
                        state_next      = S_SWEEP;
                    end
                end
                CMD_DESTROY:
                begin
                    if (!pool_ready_reg)
                    begin
                        status_next = ST_IGNORED;
                    end
                    else
                    begin
                        head_next       = '0;
                        list_empty_next = 1'b1;
                        pool_ready_next = 1'b0;
                    end
                end
                CMD_ALLOC:
                begin
                    priority if (!pool_ready_reg)
                    begin
                        status_next = ST_NOT_INIT;
                    end
                    else if (REQ_W'(request_size_reg) > REQ_W'(held_size_reg))
                    begin
                        status_next = ST_TOO_LARGE;
                    end
                    else if (list_empty_reg)
                    begin
                        status_next = ST_EXHAUSTED;
                    end
                    else
                    begin
                        granted_next = head_reg;
                        offset_next  = OFFSET_W'(product);
                        if (link_rd.last)
                        begin
                            head_next       = '0;
                            list_empty_next = 1'b1;
                        end
                        else
                        begin
                            head_next = link_rd.link;
                        end
                    end
                end
                CMD_FREE:
                begin
                    priority if (null_pointer_reg || !pool_ready_reg)
                    begin
                        status_next = ST_IGNORED;
                    end
                    else if ({1'b0, block_index_reg} >= held_count_reg)
                    begin
                        status_next = ST_BAD_INDEX;
                    end
                    else
                    begin
                        link_wr.en      = 1'b1;
                        head_next       = block_index_reg;
                        list_empty_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            block_count_reg <= COUNT_W'(NUM_BLOCKS);
            req_size_reg    <= REQ_CFG_W'(64);
            head_reg        <= '0;
            list_empty_reg  <= 1'b1;
            pool_ready_reg  <= 1'b0;
            held_count_reg  <= COUNT_W'(1);
            held_size_reg   <= SIZE_W'(ALIGN_BYTES);
            sweep_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            list_empty_reg <= list_empty_next;
            pool_ready_reg <= pool_ready_next;
            held_count_reg <= held_count_next;
            held_size_reg  <= held_size_next;
            sweep_reg      <= sweep_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_BLOCK_COUNT: block_count_reg <= cfg_data[COUNT_W-1:0];
                    REG_BLOCK_SIZE:  req_size_reg    <= cfg_data[REQ_CFG_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg          <= cmd_t'(cmd);
            request_size_reg <= request_size;
            block_index_reg  <= block_index;
            null_pointer_reg <= null_pointer;
        end
        status_reg  <= status_next;
        granted_reg <= granted_next;
        offset_reg  <= offset_next;
    end

`include "fixed_block_pool_allocator_core_assert.svh"

    `FBPA_ASSERT_NOW(a_empty_head_clear, clk, rst_n, list_empty_reg, head_reg == '0)
    `FBPA_ASSERT_NOW(a_unready_empty, clk, rst_n, !pool_ready_reg, list_empty_reg)
    `FBPA_ASSERT_NOW(a_head_in_range, clk, rst_n, !list_empty_reg, head_below_count)
    `FBPA_ASSERT_NEXT(a_exec_gives_word, clk, rst_n, exec_go, out_valid_reg)

endmodule
